[hdl/apbc_pkg.sv]
// Shared types, constants and codes for the atom pair bond classifier.
package apbc_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int DIST_WIDTH_DEF  = 12;

  localparam int REG_W  = 12;
  localparam int TYPE_W = 10;
  localparam int RES_W  = 16;
  localparam int IDX_W  = 2;
  localparam int SQ_W   = 2 * REG_W;
  localparam int ROOT_W = REG_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;

  localparam logic [TYPE_W-1:0] H_TYPE_LO = TYPE_W'(100);
  localparam logic [TYPE_W-1:0] H_TYPE_HI = TYPE_W'(199);

  localparam logic [REG_W-1:0] MAX_BOND_RST  = REG_W'(1853);
  localparam logic [REG_W-1:0] MIN_BOND_RST  = REG_W'(870);
  localparam logic [REG_W-1:0] MAX_H_RST     = REG_W'(1280);
  localparam logic [REG_W-1:0] MIN_HEAVY_RST = REG_W'(1178);

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_BOND  = 2'd0,
    REG_MIN_BOND  = 2'd1,
    REG_MAX_H     = 2'd2,
    REG_MIN_HEAVY = 2'd3
  } apbc_reg_t;

  typedef enum logic [1:0] {
    IA_CLOSE     = 2'd0,
    IA_NONBONDED = 2'd1,
    IA_BONDED    = 2'd2,
    IA_HYDROGEN  = 2'd3
  } apbc_kind_t;

  typedef struct packed {
    logic [REG_W-1:0] max_bond;
    logic [REG_W-1:0] min_bond;
    logic [REG_W-1:0] max_h;
    logic [REG_W-1:0] min_heavy;
  } apbc_cfg_t;

  typedef struct packed {
    logic reject;
    logic ha;
    logic hb;
    logic same_res;
  } apbc_tag_t;

endpackage

[hdl/apbc_if.sv]
// Channel interfaces: atom pair input, classification result, register write.
interface apbc_in_if #(
  parameter int COORD_WIDTH = apbc_pkg::COORD_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_WIDTH-1:0]     a_x;
  logic signed [COORD_WIDTH-1:0]     a_y;
  logic signed [COORD_WIDTH-1:0]     a_z;
  logic signed [COORD_WIDTH-1:0]     b_x;
  logic signed [COORD_WIDTH-1:0]     b_y;
  logic signed [COORD_WIDTH-1:0]     b_z;
  logic [apbc_pkg::TYPE_W-1:0]       a_type;
  logic [apbc_pkg::TYPE_W-1:0]       b_type;
  logic [apbc_pkg::RES_W-1:0]        a_residue;
  logic [apbc_pkg::RES_W-1:0]        b_residue;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, a_type, b_type, a_residue, b_residue,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, a_type, b_type, a_residue, b_residue,
    output ready
  );
endinterface

interface apbc_out_if #(
  parameter int DIST_WIDTH = apbc_pkg::DIST_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            interaction;
  logic [DIST_WIDTH-1:0] distance;
  logic                  distance_valid;
  logic                  close_warning;

  modport source (
    output valid, interaction, distance, distance_valid, close_warning,
    input  ready
  );
  modport sink (
    input  valid, interaction, distance, distance_valid, close_warning,
    output ready
  );
endinterface

interface apbc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [apbc_pkg::IDX_W-1:0] index;
  logic [apbc_pkg::REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/apbc_front.sv]
// Front pipeline: axis differences, axis rejection, squares and squared distance.
module apbc_front #(
  parameter int COORD_WIDTH = apbc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  apbc_in_if.sink                         in_ch,
  input  logic [apbc_pkg::REG_W-1:0]      max_bond,
  input  logic                            ready_i,
  output logic                            valid_o,
  output logic [apbc_pkg::RAD_W-1:0]      rad_o,
  output apbc_pkg::apbc_tag_t             tag_o
);

  localparam int DIFF_W = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] a_c [3];
  logic signed [COORD_WIDTH-1:0] b_c [3];

  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: signed differences both ways
  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [DIFF_W-1:0] s1_dpos_r [3];
  logic signed [DIFF_W-1:0] s1_dpos_nxt [3];
  logic signed [DIFF_W-1:0] s1_dneg_r [3];
  logic signed [DIFF_W-1:0] s1_dneg_nxt [3];
  apbc_pkg::apbc_tag_t      s1_tag_r, s1_tag_nxt;

  // stage 2: magnitudes and axis rejection
  logic                         s2_valid_r, s2_valid_nxt;
  logic [apbc_pkg::REG_W-1:0]   s2_mag_r [3];
  logic [apbc_pkg::REG_W-1:0]   s2_mag_nxt [3];
  apbc_pkg::apbc_tag_t          s2_tag_r, s2_tag_nxt;
  logic [DIFF_W-1:0]            mag [3];

  // stage 3: squares
  logic                         s3_valid_r, s3_valid_nxt;
  logic [apbc_pkg::SQ_W-1:0]    s3_sq_r [3];
  logic [apbc_pkg::SQ_W-1:0]    s3_sq_nxt [3];
  apbc_pkg::apbc_tag_t          s3_tag_r, s3_tag_nxt;

  // stage 4: sum of squares
  logic                         s4_valid_r, s4_valid_nxt;
  logic [apbc_pkg::RAD_W-1:0]   s4_sum_r, s4_sum_nxt;
  apbc_pkg::apbc_tag_t          s4_tag_r, s4_tag_nxt;

  assign a_c[0] = in_ch.a_x;
  assign a_c[1] = in_ch.a_y;
  assign a_c[2] = in_ch.a_z;
  assign b_c[0] = in_ch.b_x;
  assign b_c[1] = in_ch.b_y;
  assign b_c[2] = in_ch.b_z;

  assign rdy4 = !s4_valid_r || ready_i;
  assign rdy3 = !s3_valid_r || rdy4;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    s1_valid_nxt = rdy1 ? in_ch.valid : s1_valid_r;
    s1_tag_nxt   = s1_tag_r;
    for (int i = 0; i < 3; i++) begin
      s1_dpos_nxt[i] = s1_dpos_r[i];
      s1_dneg_nxt[i] = s1_dneg_r[i];
    end
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        s1_dpos_nxt[i] = DIFF_W'(a_c[i]) - DIFF_W'(b_c[i]);
        s1_dneg_nxt[i] = DIFF_W'(b_c[i]) - DIFF_W'(a_c[i]);
      end
      s1_tag_nxt.reject   = 1'b0;
      s1_tag_nxt.ha       = in_ch.a_type inside {[apbc_pkg::H_TYPE_LO:apbc_pkg::H_TYPE_HI]};
      s1_tag_nxt.hb       = in_ch.b_type inside {[apbc_pkg::H_TYPE_LO:apbc_pkg::H_TYPE_HI]};
      s1_tag_nxt.same_res = in_ch.a_residue == in_ch.b_residue;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = s1_dpos_r[i][DIFF_W-1] ? s1_dneg_r[i] : s1_dpos_r[i];
    end
    s2_valid_nxt = rdy2 ? s1_valid_r : s2_valid_r;
    s2_tag_nxt   = s2_tag_r;
    for (int i = 0; i < 3; i++) begin
      s2_mag_nxt[i] = s2_mag_r[i];
    end
    if (rdy2) begin
      s2_tag_nxt = s1_tag_r;
      s2_tag_nxt.reject = (mag[0] > DIFF_W'(max_bond)) || (mag[1] > DIFF_W'(max_bond)) ||
                          (mag[2] > DIFF_W'(max_bond));
      for (int i = 0; i < 3; i++) begin
        s2_mag_nxt[i] = mag[i][apbc_pkg::REG_W-1:0];
      end
    end
  end

  always_comb begin
    s3_valid_nxt = rdy3 ? s2_valid_r : s3_valid_r;
    s3_tag_nxt   = rdy3 ? s2_tag_r : s3_tag_r;
    for (int i = 0; i < 3; i++) begin
      s3_sq_nxt[i] = rdy3 ? s2_mag_r[i] * s2_mag_r[i] : s3_sq_r[i];
    end
  end

  always_comb begin
    s4_valid_nxt = rdy4 ? s3_valid_r : s4_valid_r;
    s4_tag_nxt   = rdy4 ? s3_tag_r : s4_tag_r;
    s4_sum_nxt   = rdy4 ? apbc_pkg::RAD_W'(s3_sq_r[0]) + apbc_pkg::RAD_W'(s3_sq_r[1]) +
                          apbc_pkg::RAD_W'(s3_sq_r[2])
                        : s4_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= s1_tag_nxt;
    s2_tag_r <= s2_tag_nxt;
    s3_tag_r <= s3_tag_nxt;
    s4_tag_r <= s4_tag_nxt;
    s4_sum_r <= s4_sum_nxt;
    for (int i = 0; i < 3; i++) begin
      s1_dpos_r[i] <= s1_dpos_nxt[i];
      s1_dneg_r[i] <= s1_dneg_nxt[i];
      s2_mag_r[i]  <= s2_mag_nxt[i];
      s3_sq_r[i]   <= s3_sq_nxt[i];
    end
  end

  assign valid_o = s4_valid_r;
  assign rad_o   = s4_sum_r;
  assign tag_o   = s4_tag_r;

endmodule

[hdl/apbc_sqrt_cell.sv]
// One square-root cell: decides one root bit and passes remainder and root on.
module apbc_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [apbc_pkg::RAD_W-1:0]  rem_i,
  input  logic [apbc_pkg::ROOT_W-1:0] root_i,
  input  apbc_pkg::apbc_tag_t         tag_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output logic [apbc_pkg::RAD_W-1:0]  rem_o,
  output logic [apbc_pkg::ROOT_W-1:0] root_o,
  output apbc_pkg::apbc_tag_t         tag_o,
  input  logic                        ready_i
);

  localparam int TW = apbc_pkg::RAD_W + 1;

  logic [TW-1:0]                 rem_ext;
  logic [TW-1:0]                 trial;
  logic                          take;

  logic                          valid_r, valid_nxt;
  logic [apbc_pkg::RAD_W-1:0]    rem_r, rem_nxt;
  logic [apbc_pkg::ROOT_W-1:0]   root_r, root_nxt;
  apbc_pkg::apbc_tag_t           tag_r, tag_nxt;

  assign rem_ext = {1'b0, rem_i};
  // (2*root + 2^BIT) * 2^BIT; root has no bits at or below BIT yet
  assign trial   = (TW'(root_i) << (BIT + 1)) | (TW'(1) << (2 * BIT));
  assign take    = rem_ext >= trial;
  assign ready_o = !valid_r || ready_i;

  always_comb begin
    valid_nxt = ready_o ? valid_i : valid_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    tag_nxt   = tag_r;
    if (ready_o) begin
      rem_nxt  = take ? apbc_pkg::RAD_W'(rem_ext - trial) : rem_i;
      root_nxt = take ? (root_i | (apbc_pkg::ROOT_W'(1) << BIT)) : root_i;
      tag_nxt  = tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign tag_o   = tag_r;

endmodule

[hdl/apbc_classify.sv]
// Classification against the limit registers and the result output register.
module apbc_classify #(
  parameter int DIST_WIDTH = apbc_pkg::DIST_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [apbc_pkg::ROOT_W-1:0] root_i,
  input  apbc_pkg::apbc_tag_t         tag_i,
  input  apbc_pkg::apbc_cfg_t         cfg,
  output logic                        ready_o,
  apbc_out_if.source                  out_ch
);

  logic                        below_h;
  logic                        any_h;
  logic [DIST_WIDTH-1:0]       dist_sat;
  apbc_pkg::apbc_kind_t        kind;

  logic                        valid_r, valid_nxt;
  apbc_pkg::apbc_kind_t        kind_r, kind_nxt;
  logic [DIST_WIDTH-1:0]       dist_r, dist_nxt;
  logic                        dval_r, dval_nxt;
  logic                        warn_r, warn_nxt;

  generate
    if (DIST_WIDTH >= apbc_pkg::ROOT_W) begin : g_wide
      assign dist_sat = DIST_WIDTH'(root_i);
    end else begin : g_sat
      assign dist_sat = (|root_i[apbc_pkg::ROOT_W-1:DIST_WIDTH]) ? '1
                                                                 : root_i[DIST_WIDTH-1:0];
    end
  endgenerate

  assign below_h = root_i < apbc_pkg::ROOT_W'(cfg.max_h);
  assign any_h   = tag_i.ha || tag_i.hb;
  assign ready_o = !valid_r || out_ch.ready;

  always_comb begin
    if (below_h && tag_i.ha && tag_i.hb) begin
      kind = apbc_pkg::IA_NONBONDED;
    end else if (below_h && any_h) begin
      kind = tag_i.same_res ? apbc_pkg::IA_BONDED : apbc_pkg::IA_NONBONDED;
    end else if (below_h && (root_i < apbc_pkg::ROOT_W'(cfg.min_heavy))) begin
      kind = apbc_pkg::IA_CLOSE;
    end else if (root_i <= apbc_pkg::ROOT_W'(cfg.max_bond)) begin
      kind = any_h ? apbc_pkg::IA_HYDROGEN : apbc_pkg::IA_BONDED;
    end else begin
      kind = apbc_pkg::IA_NONBONDED;
    end
  end

  always_comb begin
    valid_nxt = ready_o ? valid_i : valid_r;
    kind_nxt  = kind_r;
    dist_nxt  = dist_r;
    dval_nxt  = dval_r;
    warn_nxt  = warn_r;
    if (ready_o) begin
      if (tag_i.reject) begin
        kind_nxt = apbc_pkg::IA_NONBONDED;
        dist_nxt = '0;
        dval_nxt = 1'b0;
        warn_nxt = 1'b0;
      end else begin
        kind_nxt = kind;
        dist_nxt = dist_sat;
        dval_nxt = 1'b1;
        warn_nxt = below_h && (root_i < apbc_pkg::ROOT_W'(cfg.min_bond));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    dist_r <= dist_nxt;
    dval_r <= dval_nxt;
    warn_r <= warn_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.interaction    = kind_r;
  assign out_ch.distance       = dist_r;
  assign out_ch.distance_valid = dval_r;
  assign out_ch.close_warning  = warn_r;

endmodule

[hdl/atom_pair_bond_classifier.sv]
// Atom pair bond classifier: top level with limit registers and square-root cell row.
//
// Usage:
//   in_ch   valid/ready channel, one atom pair per transaction (coordinates,
//           type codes, residue numbers).
//   out_ch  valid/ready channel, one classification per input transaction,
//           in input order (interaction, distance, distance_valid, close_warning).
//   cfg_ch  register writes, index 0..3, always ready; write only while the
//           pipeline is empty.
// Pipeline: four front stages (differences, axis test, squares, sum), one
//   square-root cell per root bit (13 cells), one output register.
// Throughput: one pair per cycle, sustained while out_ch.ready stays high;
//   every stage holds one pair.
// Stall: when out_ch.ready is low, the output register holds its transaction and
//   each stage keeps accepting until the stage ahead of it is full; in_ch.ready
//   drops only when the whole row is occupied.
// Reset (rst_n low, synchronous): all stages emptied, limits return to their
//   default values.
module atom_pair_bond_classifier #(
  parameter int COORD_WIDTH = apbc_pkg::COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = apbc_pkg::DIST_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  apbc_in_if.sink     in_ch,
  apbc_out_if.source  out_ch,
  apbc_cfg_if.sink    cfg_ch
);

  apbc_pkg::apbc_cfg_t cfg_r, cfg_nxt;

  logic                        c_valid [apbc_pkg::ROOT_W+1];
  logic                        c_rdy   [apbc_pkg::ROOT_W+1];
  logic [apbc_pkg::RAD_W-1:0]  c_rem   [apbc_pkg::ROOT_W+1];
  logic [apbc_pkg::ROOT_W-1:0] c_root  [apbc_pkg::ROOT_W+1];
  apbc_pkg::apbc_tag_t         c_tag   [apbc_pkg::ROOT_W+1];

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        apbc_pkg::REG_MAX_BOND:  cfg_nxt.max_bond  = cfg_ch.data;
        apbc_pkg::REG_MIN_BOND:  cfg_nxt.min_bond  = cfg_ch.data;
        apbc_pkg::REG_MAX_H:     cfg_nxt.max_h     = cfg_ch.data;
        apbc_pkg::REG_MIN_HEAVY: cfg_nxt.min_heavy = cfg_ch.data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_bond  <= apbc_pkg::MAX_BOND_RST;
      cfg_r.min_bond  <= apbc_pkg::MIN_BOND_RST;
      cfg_r.max_h     <= apbc_pkg::MAX_H_RST;
      cfg_r.min_heavy <= apbc_pkg::MIN_HEAVY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apbc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .max_bond (cfg_r.max_bond),
    .ready_i  (c_rdy[0]),
    .valid_o  (c_valid[0]),
    .rad_o    (c_rem[0]),
    .tag_o    (c_tag[0])
  );

  assign c_root[0] = '0;

  generate
    for (genvar i = 0; i < apbc_pkg::ROOT_W; i++) begin : g_cell
      apbc_sqrt_cell #(
        .BIT (apbc_pkg::ROOT_W - 1 - i)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (c_valid[i]),
        .rem_i   (c_rem[i]),
        .root_i  (c_root[i]),
        .tag_i   (c_tag[i]),
        .ready_o (c_rdy[i]),
        .valid_o (c_valid[i+1]),
        .rem_o   (c_rem[i+1]),
        .root_o  (c_root[i+1]),
        .tag_o   (c_tag[i+1]),
        .ready_i (c_rdy[i+1])
      );
    end
  endgenerate

  apbc_classify #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (c_valid[apbc_pkg::ROOT_W]),
    .root_i  (c_root[apbc_pkg::ROOT_W]),
    .tag_i   (c_tag[apbc_pkg::ROOT_W]),
    .cfg     (cfg_r),
    .ready_o (c_rdy[apbc_pkg::ROOT_W]),
    .out_ch  (out_ch)
  );

endmodule

[hdl/apbc_checker.sv]
// Port-level assertions for the classifier and the bind that attaches them.
module apbc_checker #(
  parameter int DIST_WIDTH = apbc_pkg::DIST_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_interaction,
  input logic [DIST_WIDTH-1:0] out_distance,
  input logic                  out_distance_valid,
  input logic                  out_close_warning
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interaction) &&
      $stable(out_distance) && $stable(out_distance_valid) && $stable(out_close_warning))
    else $error("result changed while stalled");

  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_distance_valid |-> out_distance == '0 && !out_close_warning &&
      out_interaction == apbc_pkg::IA_NONBONDED)
    else $error("axis-rejected result carries distance data");

  a_warn_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_close_warning |->
      out_distance_valid && out_interaction != apbc_pkg::IA_HYDROGEN)
    else $error("close warning on an impossible classification");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind atom_pair_bond_classifier apbc_checker #(
  .DIST_WIDTH (DIST_WIDTH)
) u_apbc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_interaction    (out_ch.interaction),
  .out_distance       (out_ch.distance),
  .out_distance_valid (out_ch.distance_valid),
  .out_close_warning  (out_ch.close_warning)
);

[verif/atom_pair_bond_classifier_test.sv]
// Testbench for the atom pair bond classifier: randomized atom pairs checked by a local predictor.
module atom_pair_bond_classifier_test;

  localparam int CW = apbc_pkg::COORD_WIDTH_DEF;
  localparam int DW = apbc_pkg::DIST_WIDTH_DEF;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [CW-1:0]          ax, ay, az, bx, by, bz;
    logic [apbc_pkg::TYPE_W-1:0]   atype, btype;
    logic [apbc_pkg::RES_W-1:0]    ares, bres;
  } atom_pair_t;

  typedef struct packed {
    apbc_pkg::apbc_kind_t kind;
    logic [DW-1:0]        distance;
    logic                 dvalid;
    logic                 warn;
  } bond_verdict_t;

  bit   clk;
  logic rst_n = 1'b0;

  apbc_in_if  in_ch ();
  apbc_out_if out_ch ();
  apbc_cfg_if cfg_ch ();

  atom_pair_bond_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [apbc_pkg::REG_W-1:0] lim_max_bond  = apbc_pkg::MAX_BOND_RST;
  logic [apbc_pkg::REG_W-1:0] lim_min_bond  = apbc_pkg::MIN_BOND_RST;
  logic [apbc_pkg::REG_W-1:0] lim_max_h     = apbc_pkg::MAX_H_RST;
  logic [apbc_pkg::REG_W-1:0] lim_min_heavy = apbc_pkg::MIN_HEAVY_RST;

  atom_pair_t    pending_pairs[$];
  bond_verdict_t verdicts_due[$];
  bond_verdict_t due;
  atom_pair_t    seen_pair;

  int err_count   = 0;
  int idle_cycles = 0;
  int sent_cnt    = 0;
  int done_cnt    = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cnt    = 0;
  bit hold_start  = 0;
  bit in_fire     = 0;
  bit out_fire;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bond_verdict_t classify_pair(atom_pair_t p);
    longint dx, dy, dz, sum, root, trial;
    bit ha, hb, same_res, decided;
    bond_verdict_t v;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    dz = longint'(p.az) - longint'(p.bz);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    ha = p.atype inside {[apbc_pkg::H_TYPE_LO:apbc_pkg::H_TYPE_HI]};
    hb = p.btype inside {[apbc_pkg::H_TYPE_LO:apbc_pkg::H_TYPE_HI]};
    same_res = p.ares == p.bres;
    v.kind = apbc_pkg::IA_NONBONDED;
    v.distance = '0;
    v.dvalid = 1'b0;
    v.warn = 1'b0;
    if (dx > lim_max_bond || dy > lim_max_bond || dz > lim_max_bond) return v;
    sum = dx * dx + dy * dy + dz * dz;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum) root = trial;
    end
    decided = 1'b0;
    if (root < lim_max_h) begin
      v.warn = root < lim_min_bond;
      if (ha && hb) begin
        v.kind = apbc_pkg::IA_NONBONDED;
        decided = 1'b1;
      end else if (ha || hb) begin
        v.kind = same_res ? apbc_pkg::IA_BONDED : apbc_pkg::IA_NONBONDED;
        decided = 1'b1;
      end else if (root < lim_min_heavy) begin
        v.kind = apbc_pkg::IA_CLOSE;
        decided = 1'b1;
      end
    end
    if (!decided) begin
      if (root <= lim_max_bond) begin
        v.kind = (ha || hb) ? apbc_pkg::IA_HYDROGEN : apbc_pkg::IA_BONDED;
      end else begin
        v.kind = apbc_pkg::IA_NONBONDED;
      end
    end
    v.distance = (root > (2 ** DW) - 1) ? DW'((2 ** DW) - 1) : DW'(root);
    v.dvalid = 1'b1;
    return v;
  endfunction

  function automatic atom_pair_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                    int at, int bt, int ar, int br);
    atom_pair_t p;
    p.ax = CW'(ax);
    p.ay = CW'(ay);
    p.az = CW'(az);
    p.bx = CW'(bx);
    p.by = CW'(by);
    p.bz = CW'(bz);
    p.atype = apbc_pkg::TYPE_W'(at);
    p.btype = apbc_pkg::TYPE_W'(bt);
    p.ares = apbc_pkg::RES_W'(ar);
    p.bres = apbc_pkg::RES_W'(br);
    return p;
  endfunction

  function automatic logic [apbc_pkg::TYPE_W-1:0] pick_type();
    int r;
    r = $urandom_range(3);
    case (r)
      0: return apbc_pkg::TYPE_W'($urandom_range(apbc_pkg::H_TYPE_HI, apbc_pkg::H_TYPE_LO));
      1: return apbc_pkg::TYPE_W'($urandom_range(apbc_pkg::H_TYPE_LO - 1));
      2: return apbc_pkg::TYPE_W'($urandom_range(1023, apbc_pkg::H_TYPE_HI + 1));
      default: begin
        r = $urandom_range(3);
        if (r == 0) return apbc_pkg::TYPE_W'(apbc_pkg::H_TYPE_LO - 1);
        else if (r == 1) return apbc_pkg::H_TYPE_LO;
        else if (r == 2) return apbc_pkg::H_TYPE_HI;
        else return apbc_pkg::TYPE_W'(apbc_pkg::H_TYPE_HI + 1);
      end
    endcase
  endfunction

  function automatic atom_pair_t rand_pair();
    atom_pair_t p;
    int base[3];
    int off[3];
    int lims[4];
    int mode, span, t;
    mode = $urandom_range(99);
    span = int'(lim_max_bond) + int'(lim_max_bond) / 8 + 2;
    lims[0] = int'(lim_max_bond);
    lims[1] = int'(lim_min_bond);
    lims[2] = int'(lim_max_h);
    lims[3] = int'(lim_min_heavy);
    for (int k = 0; k < 3; k++) begin
      base[k] = int'($urandom_range(1000000)) - 500000;
      off[k] = int'($urandom_range(2 * span)) - span;
    end
    if (mode < 35 && mode >= 10) begin
      // single-axis distance at or one off a threshold
      off = '{0, 0, 0};
      t = lims[$urandom_range(3)] + int'($urandom_range(2)) - 1;
      if (t < 0) t = 0;
      off[$urandom_range(2)] = $urandom_range(1) ? t : -t;
    end else if (mode < 45 && mode >= 35) begin
      off = '{0, 0, 0};
    end
    p = mk(base[0], base[1], base[2], base[0] + off[0], base[1] + off[1], base[2] + off[2],
           pick_type(), pick_type(), $urandom, 0);
    p.bres = $urandom_range(1) ? p.ares : apbc_pkg::RES_W'($urandom);
    if (mode < 10) begin
      p.ax = CW'($urandom);
      p.ay = CW'($urandom);
      p.az = CW'($urandom);
      p.bx = CW'($urandom);
      p.by = CW'($urandom);
      p.bz = CW'($urandom);
      p.atype = apbc_pkg::TYPE_W'($urandom);
      p.btype = apbc_pkg::TYPE_W'($urandom);
    end
    return p;
  endfunction

  task automatic write_reg(apbc_pkg::apbc_reg_t idx, logic [apbc_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      apbc_pkg::REG_MAX_BOND:  lim_max_bond  = val;
      apbc_pkg::REG_MIN_BOND:  lim_min_bond  = val;
      apbc_pkg::REG_MAX_H:     lim_max_h     = val;
      apbc_pkg::REG_MIN_HEAVY: lim_min_heavy = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_limits(int mb, int mn, int mh, int mhv);
    write_reg(apbc_pkg::REG_MAX_BOND, apbc_pkg::REG_W'(mb));
    write_reg(apbc_pkg::REG_MIN_BOND, apbc_pkg::REG_W'(mn));
    write_reg(apbc_pkg::REG_MAX_H, apbc_pkg::REG_W'(mh));
    write_reg(apbc_pkg::REG_MIN_HEAVY, apbc_pkg::REG_W'(mhv));
  endtask

  task automatic push_random(int n);
    repeat (n) pending_pairs.push_back(rand_pair());
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || sent_cnt != done_cnt);
    repeat (24) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!in_ch.valid || in_fire) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        seen_pair = pending_pairs.pop_front();
        sent_cnt++;
        in_ch.a_x       <= seen_pair.ax;
        in_ch.a_y       <= seen_pair.ay;
        in_ch.a_z       <= seen_pair.az;
        in_ch.b_x       <= seen_pair.bx;
        in_ch.b_y       <= seen_pair.by;
        in_ch.b_z       <= seen_pair.bz;
        in_ch.a_type    <= seen_pair.atype;
        in_ch.b_type    <= seen_pair.btype;
        in_ch.a_residue <= seen_pair.ares;
        in_ch.b_residue <= seen_pair.bres;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off when hold_start is set
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 0;
      hold_cnt = 150;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // transaction monitor and checker
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
    out_fire = rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1;
    if (in_fire) begin
      verdicts_due.push_back(classify_pair(mk(in_ch.a_x, in_ch.a_y, in_ch.a_z,
                                              in_ch.b_x, in_ch.b_y, in_ch.b_z,
                                              in_ch.a_type, in_ch.b_type,
                                              in_ch.a_residue, in_ch.b_residue)));
    end
    if (out_fire) begin
      if (verdicts_due.size() == 0) begin
        $error("result with nothing pending: interaction %0d distance %0d",
               out_ch.interaction, out_ch.distance);
        err_count++;
      end else begin
        due = verdicts_due.pop_front();
        done_cnt++;
        if (out_ch.interaction !== due.kind) begin
          $error("interaction: expected %0d, got %0d", due.kind, out_ch.interaction);
          err_count++;
        end
        if (out_ch.distance !== due.distance) begin
          $error("distance: expected %0d, got %0d", due.distance, out_ch.distance);
          err_count++;
        end
        if (out_ch.distance_valid !== due.dvalid) begin
          $error("distance_valid: expected %0d, got %0d", due.dvalid, out_ch.distance_valid);
          err_count++;
        end
        if (out_ch.close_warning !== due.warn) begin
          $error("close_warning: expected %0d, got %0d", due.warn, out_ch.close_warning);
          err_count++;
        end
      end
    end
    if (in_fire || out_fire || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("atom_pair_bond_classifier_test: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.a_z = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.b_z = '0;
    in_ch.a_type = '0;
    in_ch.b_type = '0;
    in_ch.a_residue = '0;
    in_ch.b_residue = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = apbc_pkg::REG_MAX_BOND;
    cfg_ch.data = '0;
    send_idle_pct = 38;
    recv_idle_pct = 78;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default limits
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 6, 6, 1, 1));
    pending_pairs.push_back(mk(-524288, -524288, -524288, 524287, 524287, 524287,
                               0, 1023, 0, 65535));
    pending_pairs.push_back(mk(524287, 524287, 524287, -524288, -524288, -524288,
                               1023, 0, 65535, 0));
    pending_pairs.push_back(mk(0, 0, 0, 1853, 0, 0, 6, 8, 3, 4));
    pending_pairs.push_back(mk(0, 0, 0, 0, 1854, 0, 6, 8, 3, 3));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, -1854, 6, 8, 3, 3));
    pending_pairs.push_back(mk(0, 0, 0, 1500, 1500, 0, 6, 8, 3, 3));
    pending_pairs.push_back(mk(10, 20, 30, 10, 20, 530, 100, 199, 5, 5));
    pending_pairs.push_back(mk(0, 0, 0, 0, 1000, 0, 101, 6, 7, 7));
    pending_pairs.push_back(mk(0, 0, 0, 0, 1000, 0, 101, 6, 7, 8));
    pending_pairs.push_back(mk(0, 0, 0, 1279, 0, 0, 6, 150, 9, 9));
    pending_pairs.push_back(mk(0, 0, 0, 1280, 0, 0, 6, 150, 9, 9));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 1177, 99, 200, 2, 2));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 1178, 99, 200, 2, 2));
    pending_pairs.push_back(mk(0, 0, 0, 869, 0, 0, 6, 6, 1, 2));
    pending_pairs.push_back(mk(0, 0, 0, 870, 0, 0, 6, 6, 1, 2));
    pending_pairs.push_back(mk(-100, -100, -100, -600, -700, -800, 12, 300, 4, 4));
    pending_pairs.push_back(mk(-524288, 0, 0, -523288, 0, 0, 101, 102, 4, 4));
    pending_pairs.push_back(mk(0, 0, 0, 1300, 1300, 0, 150, 6, 4, 5));
    pending_pairs.push_back(mk(0, 0, 0, 1300, 1300, 0, 150, 120, 4, 4));
    push_random(480);
    drain();

    // wide limits: saturated distance, warning outside the hydrogen branch
    set_limits(4095, 4095, 3000, 2500);
    pending_pairs.push_back(mk(0, 0, 0, 4095, 4095, 4095, 6, 6, 1, 1));
    pending_pairs.push_back(mk(0, 0, 0, 3500, 0, 0, 6, 6, 1, 1));
    pending_pairs.push_back(mk(0, 0, 0, 100, 0, 0, 6, 6, 1, 1));
    pending_pairs.push_back(mk(0, 0, 0, 4096, 0, 0, 6, 6, 1, 1));
    push_random(100);
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 38;
    set_limits(0, 0, 0, 0);
    pending_pairs.push_back(mk(5, 5, 5, 5, 5, 5, 6, 6, 1, 1));
    pending_pairs.push_back(mk(5, 5, 5, 5, 5, 5, 150, 6, 1, 1));
    pending_pairs.push_back(mk(0, 0, 0, 1, 0, 0, 6, 6, 1, 1));
    push_random(40);
    drain();

    set_limits($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
               $urandom_range(4095));
    push_random(500);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits($urandom_range(4095, 1200), $urandom_range(900), $urandom_range(1800, 900),
               $urandom_range(1500, 600));
    hold_start = 1;
    push_random(400);
    drain();

    set_limits(2000, 1000, 4095, 4095);
    push_random(250);
    drain();

    if (err_count == 0) begin
      $display("atom_pair_bond_classifier_test: done, clean");
    end else begin
      $display("atom_pair_bond_classifier_test: done, errors");
    end
    $finish;
  end

endmodule
